### rtl/core/lws_pkg.sv
// Shared widths, codes and stage records for the LFO waveform sample evaluator.
package lws_pkg;

    localparam int PHASE_BITS = 16;
    localparam int AMP_BITS   = 16;
    localparam int KIND_W     = 3;
    localparam int SAMPLE_W   = 32;
    localparam int FACT_W     = PHASE_BITS + 2;
    localparam int GAIN_W     = AMP_BITS + 2;
    localparam int PROD_W     = FACT_W + GAIN_W;
    localparam int CMP_W      = PHASE_BITS + 4;
    localparam int IN_DATA_W  = ((2 * PHASE_BITS + AMP_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((SAMPLE_W + 7) / 8) * 8;
    localparam int FRONT_STAGES = 3;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE     = 3'd0,
        KIND_TRIANGLE = 3'd1,
        KIND_SAW      = 3'd2,
        KIND_SQUARE   = 3'd3,
        KIND_STEPTRI4 = 3'd4,
        KIND_STEPTRI6 = 3'd5,
        KIND_STEPSAW4 = 3'd6,
        KIND_STEPSAW6 = 3'd7
    } kind_t;

    // Level chosen for a sample before it is scaled and divided
    typedef enum logic [2:0] {
        TERM_ZERO,
        TERM_HALF,
        TERM_SIXTH,
        TERM_TENTH,
        TERM_3TENTH,
        TERM_RATIO
    } term_t;

    // Product and divisor handed from the front end to the divider
    typedef struct packed {
        logic signed [PROD_W-1:0] prod;
        logic [PHASE_BITS-1:0]    divisor;
        logic                     neg;
    } prod_t;

    // One divider stage: partial remainder, dividend/quotient shift word
    typedef struct packed {
        logic [PHASE_BITS-1:0] rem;
        logic [PROD_W-1:0]     quo;
        logic [PHASE_BITS-1:0] divisor;
        logic                  neg;
    } div_t;

endpackage

### rtl/core/lfo_waveform_shape_eval.sv
// LFO waveform sample evaluator: front end, divider pipeline and output register.
// Stages from input beat to output beat: 3 front, 36 divider, 1 output.
// Throughput: one beat per cycle while the output is not stalled; the one-bit-per-stage divider sets the depth.
// A stall on the output holds every stage in place; nothing is lost or repeated.
// Reset (rst_n low, asynchronous) clears all valid bits; payload is not reset.
module lfo_waveform_shape_eval (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // phase [15:0], amplitude [31:16], period [47:32]
    input  logic [lws_pkg::IN_DATA_W-1:0]    s_tdata,
    // kind [2:0]
    input  logic [lws_pkg::KIND_W-1:0]       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // sample_value [31:0]
    output logic [lws_pkg::OUT_DATA_W-1:0]   m_tdata
);
    import lws_pkg::*;

    logic  adv;
    logic  prod_valid, div_valid;
    prod_t prod;
    div_t  dres;

    logic                        out_valid_reg;
    logic [SAMPLE_W-1:0]         out_reg, out_next;
    logic [PROD_W+SAMPLE_W-1:0]  qx;

    // Move the whole pipe when the output beat is free or taken
    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;

    lws_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (s_tvalid),
        .in_kind    (s_tuser),
        .in_data    (s_tdata),
        .prod_valid (prod_valid),
        .prod_out   (prod)
    );

    lws_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (prod_valid),
        .in_prod   (prod),
        .out_valid (div_valid),
        .out_div   (dres)
    );

    // Restore the sign and keep the low word
    always_comb
    begin
        qx       = {{SAMPLE_W{1'b0}}, dres.quo};
        out_next = dres.neg ? -qx[SAMPLE_W-1:0] : qx[SAMPLE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= div_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'(out_reg);

endmodule

### rtl/core/lws_front.sv
// Front end: input register, shape decode, and signed product stage.
module lws_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            adv,
    input  logic                            in_valid,
    input  logic [lws_pkg::KIND_W-1:0]      in_kind,
    input  logic [lws_pkg::IN_DATA_W-1:0]   in_data,
    output logic                            prod_valid,
    output lws_pkg::prod_t                  prod_out
);
    import lws_pkg::*;

    logic                   v1_reg, v2_reg, v3_reg;
    kind_t                  kind_reg;
    logic [PHASE_BITS-1:0]  x_reg, z_reg;
    logic signed [AMP_BITS-1:0] y_reg;

    logic signed [FACT_W-1:0] f_reg, f_next;
    logic signed [GAIN_W-1:0] g_reg, g_next;
    logic [PHASE_BITS-1:0]    d_reg, d_next;
    logic                     n_reg, n_next;

    prod_t p_reg;

    logic [CMP_W-1:0] cx, cz;
    logic lt_q1, lt_h, lt_q3, lt_s1, lt_s2, lt_s4, lt_s5;
    logic [PHASE_BITS-1:0] h;
    logic signed [GAIN_W-1:0] ye, hy, y3;
    logic signed [FACT_W-1:0] xe, he, ze;
    term_t term;
    logic  neg;
    logic signed [FACT_W-1:0] rf;
    logic [PHASE_BITS-1:0]    rd;

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Hold payload through the stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            kind_reg <= kind_t'(in_kind);
            x_reg    <= in_data[PHASE_BITS-1:0];
            y_reg    <= in_data[PHASE_BITS+AMP_BITS-1:PHASE_BITS];
            z_reg    <= in_data[2*PHASE_BITS+AMP_BITS-1:PHASE_BITS+AMP_BITS];
            f_reg    <= f_next;
            g_reg    <= g_next;
            d_reg    <= d_next;
            n_reg    <= n_next;
            p_reg.prod    <= f_reg * g_reg;
            p_reg.divisor <= d_reg;
            p_reg.neg     <= n_reg;
        end
    end

    // Bin thresholds: x < floor(k*z/m) exactly when m*(x+1) <= k*z
    always_comb
    begin
        cx = CMP_W'(x_reg) + CMP_W'(1);
        cz = CMP_W'(z_reg);
        lt_q1 = (cx << 2) <= cz;
        lt_h  = (cx << 1) <= cz;
        lt_q3 = (cx << 2) <= (cz + (cz << 1));
        lt_s1 = ((cx << 2) + (cx << 1)) <= cz;
        lt_s2 = (cx + (cx << 1)) <= cz;
        lt_s4 = (cx + (cx << 1)) <= (cz << 1);
        lt_s5 = ((cx << 2) + (cx << 1)) <= ((cz << 2) + cz);
    end

    // Operands derived from amplitude and phase
    always_comb
    begin
        h  = z_reg >> 1;
        ye = {{2{y_reg[AMP_BITS-1]}}, y_reg};
        hy = ye >>> 1;
        y3 = ye + (ye <<< 1);
        xe = {2'b00, x_reg};
        he = {2'b00, h};
        ze = {2'b00, z_reg};
    end

    // Pick the level for the selected shape
    always_comb
    begin
        term = TERM_ZERO;
        neg  = 1'b0;
        rf   = '0;
        rd   = PHASE_BITS'(1);
        case (kind_reg)
            KIND_TRIANGLE:
            begin
                if (h != '0)
                begin
                    term = TERM_RATIO;
                    rd   = h;
                    if (lt_q1)
                        rf = xe;
                    else if (lt_q3)
                        rf = he - xe;
                    else
                        rf = xe - ze;
                end
            end
            KIND_SAW:
            begin
                if (z_reg != '0)
                begin
                    term = TERM_RATIO;
                    rd   = z_reg;
                    rf   = he - xe;
                end
            end
            KIND_SQUARE:
            begin
                term = TERM_HALF;
                neg  = !lt_h;
            end
            KIND_STEPTRI4:
            begin
                if (lt_q1)
                begin
                    term = TERM_HALF;
                    neg  = 1'b1;
                end
                else if (lt_h)
                    term = TERM_ZERO;
                else if (lt_q3)
                    term = TERM_HALF;
                else
                    term = TERM_ZERO;
            end
            KIND_STEPTRI6:
            begin
                if (lt_s1)
                begin
                    term = TERM_HALF;
                    neg  = 1'b1;
                end
                else if (lt_s2)
                begin
                    term = TERM_SIXTH;
                    neg  = 1'b1;
                end
                else if (lt_h)
                    term = TERM_SIXTH;
                else if (lt_s4)
                    term = TERM_HALF;
                else if (lt_s5)
                    term = TERM_SIXTH;
                else
                begin
                    term = TERM_SIXTH;
                    neg  = 1'b1;
                end
            end
            KIND_STEPSAW4:
            begin
                if (lt_q1)
                    term = TERM_HALF;
                else if (lt_h)
                    term = TERM_SIXTH;
                else if (lt_q3)
                begin
                    term = TERM_SIXTH;
                    neg  = 1'b1;
                end
                else
                begin
                    term = TERM_HALF;
                    neg  = 1'b1;
                end
            end
            KIND_STEPSAW6:
            begin
                if (lt_s1)
                    term = TERM_HALF;
                else if (lt_s2)
                    term = TERM_3TENTH;
                else if (lt_h)
                    term = TERM_TENTH;
                else if (lt_s4)
                begin
                    term = TERM_TENTH;
                    neg  = 1'b1;
                end
                else if (lt_s5)
                begin
                    term = TERM_3TENTH;
                    neg  = 1'b1;
                end
                else
                begin
                    term = TERM_HALF;
                    neg  = 1'b1;
                end
            end
            default:
                term = TERM_ZERO;
        endcase
    end

    // Map the level onto factor, gain and divisor
    always_comb
    begin
        f_next = FACT_W'(1);
        g_next = '0;
        d_next = PHASE_BITS'(1);
        n_next = neg;
        case (term)
            TERM_HALF:
                g_next = hy;
            TERM_SIXTH:
            begin
                g_next = ye;
                d_next = PHASE_BITS'(6);
            end
            TERM_TENTH:
            begin
                g_next = ye;
                d_next = PHASE_BITS'(10);
            end
            TERM_3TENTH:
            begin
                g_next = y3;
                d_next = PHASE_BITS'(10);
            end
            TERM_RATIO:
            begin
                f_next = rf;
                g_next = ye;
                d_next = rd;
            end
            default:
            begin
                f_next = '0;
                g_next = '0;
            end
        endcase
    end

    assign prod_valid = v3_reg;
    assign prod_out   = p_reg;

endmodule

### rtl/core/lws_div.sv
// Pipelined restoring divider: one quotient bit per stage, magnitude in, sign carried.
module lws_div (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           in_valid,
    input  lws_pkg::prod_t in_prod,
    output logic           out_valid,
    output lws_pkg::div_t  out_div
);
    import lws_pkg::*;

    div_t st_in  [PROD_W];
    div_t st_reg [PROD_W];
    logic vld_reg [PROD_W];
    logic sgn;

    // Split the product into sign and magnitude
    always_comb
    begin
        sgn = in_prod.prod[PROD_W-1];
        st_in[0].rem     = '0;
        st_in[0].quo     = sgn ? PROD_W'(-in_prod.prod) : PROD_W'(in_prod.prod);
        st_in[0].divisor = in_prod.divisor;
        st_in[0].neg     = in_prod.neg ^ sgn;
    end

    for (genvar i = 0; i < PROD_W; i++)
    begin : g_stage
        logic [PHASE_BITS:0] trial;
        logic                fits;
        div_t                step;

        if (i > 0)
        begin : g_link
            assign st_in[i] = st_reg[i-1];
        end

        // Shift in one dividend bit, subtract when the divisor fits
        always_comb
        begin
            trial = {st_in[i].rem, st_in[i].quo[PROD_W-1]};
            fits  = trial >= {1'b0, st_in[i].divisor};
            step  = st_in[i];
            step.rem = fits ? PHASE_BITS'(trial - {1'b0, st_in[i].divisor})
                            : trial[PHASE_BITS-1:0];
            step.quo = {st_in[i].quo[PROD_W-2:0], fits};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i] <= 1'b0;
            else if (adv)
                vld_reg[i] <= (i == 0) ? in_valid : vld_reg[(i == 0) ? 0 : i - 1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                st_reg[i] <= step;
        end
    end

    assign out_valid = vld_reg[PROD_W-1];
    assign out_div   = st_reg[PROD_W-1];

endmodule

### bench/tb_lfo_waveform_shape_eval.sv
// Testbench for the LFO waveform sample evaluator: random and directed beats, scoreboard check.
module tb_lfo_waveform_shape_eval;

    import lws_pkg::*;

    localparam int LATENCY   = 40;
    localparam int N_RANDOM  = 850;
    localparam int STALL_MAX = 14;
    localparam int IDLE_LIMIT = 2000;

    typedef struct {
        kind_t             kind;
        logic [15:0]       phase;
        logic signed [15:0] amp;
        logic [15:0]       period;
    } sample_req_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata;
    logic [KIND_W-1:0] s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;

    sample_req_t pending_reqs[$];
    logic [31:0] expected_samples[$];
    int errors;
    int n_sent;
    int n_checked;
    int kind_hits[8];
    bit stim_done;
    bit hold_off;

    lfo_waveform_shape_eval u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // floor(v / 2)
    function automatic longint halve_floor(longint v);
        return v >>> 1;
    endfunction

    // Compute the waveform value for one request
    function automatic logic [31:0] shape_value(sample_req_t r);
        longint x;
        longint y;
        longint z;
        longint h;
        longint v;
        x = r.phase;
        y = r.amp;
        z = r.period;
        h = z / 2;
        v = 0;
        case (r.kind)
            KIND_TRIANGLE:
                if (h == 0) v = 0;
                else if (x < z / 4) v = (x * y) / h;
                else if (x < (z * 3) / 4) v = ((h - x) * y) / h;
                else v = ((x - z) * y) / h;
            KIND_SAW:
                v = (z == 0) ? 0 : ((h - x) * y) / z;
            KIND_SQUARE:
                v = (h > x) ? halve_floor(y) : -halve_floor(y);
            KIND_STEPTRI4:
                if (x < z / 4) v = -halve_floor(y);
                else if (x < z / 2) v = 0;
                else if (x < (z * 3) / 4) v = halve_floor(y);
                else v = 0;
            KIND_STEPTRI6:
                if (x < z / 6) v = -halve_floor(y);
                else if (x < z / 3) v = -(y / 6);
                else if (x < z / 2) v = y / 6;
                else if (x < (z * 2) / 3) v = halve_floor(y);
                else if (x < (z * 5) / 6) v = y / 6;
                else v = -(y / 6);
            KIND_STEPSAW4:
                if (x < z / 4) v = halve_floor(y);
                else if (x < z / 2) v = y / 6;
                else if (x < (z * 3) / 4) v = -(y / 6);
                else v = -halve_floor(y);
            KIND_STEPSAW6:
                if (x < z / 6) v = halve_floor(y);
                else if (x < z / 3) v = (3 * y) / 10;
                else if (x < z / 2) v = y / 10;
                else if (x < (z * 2) / 3) v = -(y / 10);
                else if (x < (z * 5) / 6) v = -((3 * y) / 10);
                else v = -halve_floor(y);
            default: v = 0;
        endcase
        return v[31:0];
    endfunction

    task automatic report_mismatch(string what);
        errors++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    task automatic push_req(int k, int ph, int a, int per);
        sample_req_t r;
        r.kind = kind_t'(k[2:0]);
        r.phase = ph[15:0];
        r.amp = a[15:0];
        r.period = per[15:0];
        pending_reqs.push_back(r);
    endtask

    // Fill the request queue: directed corners, then random beats
    initial
    begin
        int per;
        stim_done = 1'b0;
        hold_off = 1'b0;
        for (int k = 0; k < 8; k++)
        begin
            push_req(k, 0, 32767, 65535);
            push_req(k, 65535, -32768, 65535);
        end
        push_req(KIND_TRIANGLE, 0, 100, 0);
        push_req(KIND_TRIANGLE, 1, -5, 1);
        push_req(KIND_SAW, 5, 77, 0);
        push_req(KIND_SQUARE, 3, -1, 2);
        push_req(KIND_STEPSAW6, 40000, -32768, 2);
        push_req(KIND_TRIANGLE, 32768, -32768, 65535);
        push_req(KIND_STEPTRI6, 12, -7, 13);
        push_req(KIND_SAW, 0, -32768, 65535);
        wait (rst_n);
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == N_RANDOM / 2)
            begin
                // Pause until the pipeline has drained
                wait (pending_reqs.size() == 0 && !s_tvalid && expected_samples.size() == 0);
                hold_off = 1'b1;
                repeat (LATENCY + 5) @(posedge clk);
                hold_off = 1'b0;
            end
            case ($urandom_range(0, 3))
                0: per = $urandom_range(0, 65535);
                1: per = $urandom_range(0, 12);
                default: per = $urandom_range(2, 1000);
            endcase
            push_req($urandom_range(0, 7),
                     ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                  : $urandom_range(0, (per > 0) ? per - 1 : 0),
                     $urandom_range(0, 65535), per);
        end
        stim_done = 1'b1;
    end

    // Driver: present the next request after a random gap
    int gap_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            gap_left = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                sample_req_t r;
                r.kind = kind_t'(s_tuser);
                r.phase = s_tdata[15:0];
                r.amp = s_tdata[31:16];
                r.period = s_tdata[47:32];
                expected_samples.push_back(shape_value(r));
                kind_hits[s_tuser]++;
                n_sent++;
                gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, STALL_MAX);
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0 || hold_off || pending_reqs.size() == 0)
                begin
                    s_tvalid <= 1'b0;
                    if (gap_left > 0) gap_left--;
                end
                else
                begin
                    sample_req_t r;
                    r = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= r.kind;
                    s_tdata  <= {r.period, r.amp, r.phase};
                end
            end
        end
    end

    // Monitor: random stalls on the output, compare each beat
    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_samples.size() == 0)
                    report_mismatch($sformatf("unexpected beat %h", m_tdata));
                else
                begin
                    logic [31:0] exp_v;
                    exp_v = expected_samples.pop_front();
                    if (m_tdata[31:0] !== exp_v)
                        report_mismatch($sformatf("sample_value got %h expected %h",
                                                  m_tdata[31:0], exp_v));
                end
                n_checked++;
                stall_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, STALL_MAX);
            end
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Reset, watchdog and end of run
    initial
    begin
        int idle;
        errors = 0;
        n_sent = 0;
        n_checked = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        idle = 0;
        while (!(stim_done && pending_reqs.size() == 0 && !s_tvalid
                 && expected_samples.size() == 0))
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
            else idle++;
            if (idle >= IDLE_LIMIT)
            begin
                $display("Timeout: %0d results outstanding", expected_samples.size());
                $display("FAILURE");
                $finish;
            end
        end
        repeat (LATENCY + 20) @(posedge clk);
        $display("Ran %0d beats in, %0d checked; per-shape counts %0d %0d %0d %0d %0d %0d %0d %0d",
                 n_sent, n_checked, kind_hits[0], kind_hits[1], kind_hits[2], kind_hits[3],
                 kind_hits[4], kind_hits[5], kind_hits[6], kind_hits[7]);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
